@@ rtl/core/tzr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package tzr_pkg;

    localparam int ZONE_W  = 6;
    localparam int DIST_W  = 16;
    localparam int SUM_W   = 23;
    localparam int COUNT_W = 7;
    localparam int RUN_W   = 16;
    localparam int MEM_DEPTH = 64;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;
    localparam logic [RUN_W-1:0]   RUN_MAX   = 16'hFFFF;

    localparam logic [DIST_W-1:0] MIN_INIT = 16'h7FFF;
    localparam logic [DIST_W-1:0] MAX_INIT = 16'h8000;
    localparam logic [DIST_W-1:0] INVALID_VALUE = 16'hFFFF;

    localparam logic [7:0] STATUS_VALID_A = 8'd5;
    localparam logic [7:0] STATUS_VALID_B = 8'd9;

    localparam logic [1:0] REG_AREA_MODE = 2'd0;
    localparam logic [1:0] REG_THRESHOLD = 2'd1;
    localparam logic [1:0] REG_HOLD      = 2'd2;

    typedef enum logic [1:0] {
        KIND_FULL   = 2'd0,
        KIND_COLUMN = 2'd1,
        KIND_ROW    = 2'd2,
        KIND_POINT  = 2'd3
    } area_kind_t;

    typedef enum logic [1:0] {
        SEL_MIN  = 2'd0,
        SEL_MAX  = 2'd1,
        SEL_MEAN = 2'd2,
        SEL_ALL  = 2'd3
    } area_sel_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FINISH,
        ST_DIV,
        ST_DUMP,
        ST_DRAIN
    } ctrl_state_t;

endpackage

`default_nettype wire

@@ rtl/core/tzr_area_mem.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tzr_area_mem (
    input  wire logic                        clk,
    input  wire logic                        wr_en,
    input  wire logic [tzr_pkg::ZONE_W-1:0]  wr_addr,
    input  wire logic [tzr_pkg::DIST_W-1:0]  wr_data,
    input  wire logic                        rd_en,
    input  wire logic [tzr_pkg::ZONE_W-1:0]  rd_addr,
    output logic      [tzr_pkg::DIST_W-1:0]  rd_data
);

    logic [tzr_pkg::DIST_W-1:0] mem [tzr_pkg::MEM_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/tzr_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tzr_div (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    input  wire logic signed [tzr_pkg::SUM_W-1:0]    dividend,
    input  wire logic        [tzr_pkg::COUNT_W-1:0]  divisor,
    output logic                                     done,
    output logic signed      [tzr_pkg::DIST_W-1:0]   quotient
);

    localparam int MAG_W = tzr_pkg::SUM_W - 1;
    localparam int CNT_W = $clog2(MAG_W);

    logic                       run_reg, run_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic [tzr_pkg::COUNT_W:0]  rem_reg, rem_next;
    logic [MAG_W-1:0]           q_reg, q_next;
    logic [tzr_pkg::COUNT_W-1:0] div_reg, div_next;
    logic                       neg_reg, neg_next;
    logic                       done_reg, done_next;
    logic [tzr_pkg::SUM_W-1:0]  mag;
    logic [tzr_pkg::COUNT_W:0]  trial;
    logic                       ge;

    always_comb
    begin
        mag      = dividend[tzr_pkg::SUM_W-1] ? -dividend : dividend;
        trial    = {rem_reg[tzr_pkg::COUNT_W-1:0], q_reg[MAG_W-1]};
        ge       = trial >= {1'b0, div_reg};
        run_next = run_reg;
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        q_next   = q_reg;
        div_next = div_reg;
        neg_next = neg_reg;
        done_next = 1'b0;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            rem_next = '0;
            q_next   = mag[MAG_W-1:0];
            div_next = divisor;
            neg_next = dividend[tzr_pkg::SUM_W-1];
        end
        else if (run_reg)
        begin
            rem_next = ge ? trial - {1'b0, div_reg} : trial;
            q_next   = {q_reg[MAG_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(MAG_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        div_reg <= div_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -q_reg[tzr_pkg::DIST_W-1:0] : q_reg[tzr_pkg::DIST_W-1:0];

endmodule

`default_nettype wire

@@ rtl/core/tof_zone_reduce_threshold_unit.sv @@
// One zone item per cycle while busy is low; an item without frame end leaves busy low.
// Frame end: min, max or no-valid result is registered from the finish state and strobed,
// busy holding off items in that state; mean is strobed once the bit-serial divider has
// done its 22 steps, busy until then; an area list of N elements is strobed one per cycle,
// busy through dump and drain. Results are strobed once; the receiver cannot stall.
// Reset clears control, statistics, detector and registers; area store is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module tof_zone_reduce_threshold_unit #(
    parameter int MATRIX_WIDTH = 8
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [15:0] distance,
    input  wire logic        [7:0]  target_status,
    input  wire logic        [5:0]  zone_index,
    input  wire logic               frame_last,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic        [1:0]  cfg_index,
    input  wire logic        [15:0] cfg_data,
    output logic                    result_strobe,
    output logic signed      [15:0] result_value,
    output logic             [5:0]  element_index,
    output logic                    last_result,
    output logic                    below_threshold,
    output logic                    threshold_event,
    output logic                    result_status
);

    localparam logic [3:0] MW_C   = 4'(MATRIX_WIDTH);
    localparam logic [2:0] MAX_C  = 3'(MATRIX_WIDTH - 1);
    localparam logic [6:0] ZONES  = 7'(MATRIX_WIDTH * MATRIX_WIDTH);
    localparam logic [5:0] ROW_STEP = 6'(MATRIX_WIDTH);

    tzr_pkg::ctrl_state_t state_reg, state_next;

    logic [7:0]  area_mode_reg;
    logic [15:0] threshold_reg;
    logic [15:0] hold_reg;

    logic [tzr_pkg::COUNT_W-1:0]      count_reg;
    logic signed [tzr_pkg::SUM_W-1:0] sum_reg;
    logic signed [15:0]               min_reg, max_reg;

    logic                    prev_cmp_reg;
    logic [tzr_pkg::RUN_W-1:0] run_reg;
    logic                    below_reg;

    logic [2:0] dx_reg, dy_reg;
    logic [5:0] base_reg, n_reg;
    logic       p_valid_reg, p_last_reg;
    logic [5:0] p_idx_reg;

    logic signed [15:0] out_value_reg;
    logic [5:0]  out_idx_reg;
    logic        out_strobe_reg, out_last_reg, out_below_reg, out_event_reg, out_err_reg;

    tzr_pkg::area_kind_t kind;
    tzr_pkg::area_sel_t  sel;
    logic [2:0] x0, x1, y0, y1;
    logic       area_empty, one_elem;

    logic [2:0] zx, zy;
    logic [5:0] zbase;
    logic       in_area, status_ok, accept;

    logic [15:0] rd_data;
    logic        div_done;
    logic signed [15:0] div_q;

    logic        emit, emit_last, emit_err, det_en, div_start, dump_init, fin_err;
    logic signed [15:0] emit_value;
    logic [5:0]  emit_idx;

    logic        cur_cmp, det_event, below_upd;
    logic [tzr_pkg::RUN_W-1:0] run_upd;

    // area decode
    always_comb
    begin
        kind = tzr_pkg::area_kind_t'(area_mode_reg[7:6]);
        sel  = tzr_pkg::area_sel_t'(area_mode_reg[5:4]);
        x0 = '0;
        x1 = MAX_C;
        y0 = '0;
        y1 = MAX_C;
        unique case (kind)
            tzr_pkg::KIND_FULL:
            begin
            end
            tzr_pkg::KIND_COLUMN:
            begin
                x0 = area_mode_reg[2:0];
                x1 = area_mode_reg[2:0];
            end
            tzr_pkg::KIND_ROW:
            begin
                y0 = area_mode_reg[2:0];
                y1 = area_mode_reg[2:0];
            end
            tzr_pkg::KIND_POINT:
            begin
                x0  = area_mode_reg[2:0];
                x1  = area_mode_reg[2:0];
                y0  = area_mode_reg[5:3];
                y1  = area_mode_reg[5:3];
                sel = tzr_pkg::SEL_MIN;
            end
            default:
            begin
            end
        endcase
        area_empty = ({1'b0, x0} >= MW_C) || ({1'b0, y0} >= MW_C);
        one_elem   = (x0 == x1) && (y0 == y1);
    end

    // split zone index into column and row
    always_comb
    begin
        zy    = '0;
        zbase = '0;
        for (int k = 1; k < MATRIX_WIDTH; k++)
        begin
            if (zone_index >= 6'(k * MATRIX_WIDTH))
            begin
                zy    = 3'(k);
                zbase = 6'(k * MATRIX_WIDTH);
            end
        end
        zx = 3'(zone_index - zbase);
        in_area = ({1'b0, zone_index} < ZONES) && !area_empty
                  && (zx >= x0) && (zx <= x1) && (zy >= y0) && (zy <= y1);
        status_ok = (target_status == tzr_pkg::STATUS_VALID_A)
                    || (target_status == tzr_pkg::STATUS_VALID_B);
    end

    assign busy      = (state_reg != tzr_pkg::ST_IDLE);
    assign accept    = start && !busy;
    assign cfg_ready = !busy;
    assign fin_err   = (count_reg == '0) || area_empty;

    tzr_area_mem u_mem (
        .clk     (clk),
        .wr_en   (accept && in_area),
        .wr_addr (zone_index),
        .wr_data (status_ok ? distance : tzr_pkg::INVALID_VALUE),
        .rd_en   (state_reg == tzr_pkg::ST_DUMP),
        .rd_addr (base_reg + {3'b000, dx_reg}),
        .rd_data (rd_data)
    );

    tzr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tzr_pkg::ST_IDLE:
            begin
                if (accept && frame_last)
                begin
                    state_next = tzr_pkg::ST_FINISH;
                end
            end
            tzr_pkg::ST_FINISH:
            begin
                if (fin_err)
                begin
                    state_next = tzr_pkg::ST_IDLE;
                end
                else if (sel == tzr_pkg::SEL_ALL)
                begin
                    state_next = tzr_pkg::ST_DUMP;
                end
                else if (sel == tzr_pkg::SEL_MEAN)
                begin
                    state_next = tzr_pkg::ST_DIV;
                end
                else
                begin
                    state_next = tzr_pkg::ST_IDLE;
                end
            end
            tzr_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = tzr_pkg::ST_IDLE;
                end
            end
            tzr_pkg::ST_DUMP:
            begin
                if ((dx_reg == x1) && (dy_reg == y1))
                begin
                    state_next = tzr_pkg::ST_DRAIN;
                end
            end
            tzr_pkg::ST_DRAIN:
            begin
                state_next = tzr_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = tzr_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        emit       = 1'b0;
        emit_value = '0;
        emit_idx   = '0;
        emit_last  = 1'b1;
        emit_err   = 1'b0;
        det_en     = 1'b0;
        div_start  = 1'b0;
        dump_init  = 1'b0;
        unique case (state_reg) inside
            tzr_pkg::ST_FINISH:
            begin
                if (fin_err)
                begin
                    emit     = 1'b1;
                    emit_err = 1'b1;
                end
                else if (sel == tzr_pkg::SEL_ALL)
                begin
                    dump_init = 1'b1;
                end
                else if (sel == tzr_pkg::SEL_MEAN)
                begin
                    div_start = 1'b1;
                end
                else
                begin
                    emit       = 1'b1;
                    det_en     = 1'b1;
                    emit_value = (sel == tzr_pkg::SEL_MIN) ? min_reg : max_reg;
                end
            end
            tzr_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    emit       = 1'b1;
                    det_en     = 1'b1;
                    emit_value = div_q;
                end
            end
            tzr_pkg::ST_IDLE, tzr_pkg::ST_DUMP, tzr_pkg::ST_DRAIN:
            begin
                if (p_valid_reg)
                begin
                    emit       = 1'b1;
                    det_en     = one_elem;
                    emit_value = rd_data;
                    emit_idx   = p_idx_reg;
                    emit_last  = p_last_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // debounced threshold detector
    always_comb
    begin
        cur_cmp = $signed({emit_value[15], emit_value}) < $signed({1'b0, threshold_reg});
        if (cur_cmp == prev_cmp_reg)
        begin
            run_upd = (run_reg == tzr_pkg::RUN_MAX) ? run_reg : run_reg + 1'b1;
        end
        else
        begin
            run_upd = '0;
        end
        det_event = det_en && (run_upd >= hold_reg) && (below_reg != cur_cmp);
        below_upd = det_event ? cur_cmp : below_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= tzr_pkg::ST_IDLE;
            area_mode_reg  <= '0;
            threshold_reg  <= '0;
            hold_reg       <= '0;
            count_reg      <= '0;
            sum_reg        <= '0;
            min_reg        <= tzr_pkg::MIN_INIT;
            max_reg        <= tzr_pkg::MAX_INIT;
            prev_cmp_reg   <= 1'b0;
            run_reg        <= '0;
            below_reg      <= 1'b0;
            p_valid_reg    <= 1'b0;
            out_strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    tzr_pkg::REG_AREA_MODE: area_mode_reg <= cfg_data[7:0];
                    tzr_pkg::REG_THRESHOLD: threshold_reg <= cfg_data;
                    tzr_pkg::REG_HOLD:      hold_reg      <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end

            if (state_reg == tzr_pkg::ST_FINISH)
            begin
                count_reg <= '0;
                sum_reg   <= '0;
                min_reg   <= tzr_pkg::MIN_INIT;
                max_reg   <= tzr_pkg::MAX_INIT;
            end
            else if (accept && in_area && status_ok)
            begin
                if (count_reg < tzr_pkg::COUNT_MAX)
                begin
                    count_reg <= count_reg + 1'b1;
                    sum_reg   <= sum_reg + {{(tzr_pkg::SUM_W-16){distance[15]}}, distance};
                end
                if (distance < min_reg)
                begin
                    min_reg <= distance;
                end
                if (distance > max_reg)
                begin
                    max_reg <= distance;
                end
            end

            if (det_en)
            begin
                prev_cmp_reg <= cur_cmp;
                run_reg      <= run_upd;
                below_reg    <= below_upd;
            end

            p_valid_reg    <= (state_reg == tzr_pkg::ST_DUMP);
            out_strobe_reg <= emit;
        end
    end

    // area list walk
    always_ff @(posedge clk)
    begin
        if (dump_init)
        begin
            dx_reg   <= x0;
            dy_reg   <= y0;
            base_reg <= 6'(y0 * MATRIX_WIDTH);
            n_reg    <= '0;
        end
        else if (state_reg == tzr_pkg::ST_DUMP)
        begin
            n_reg <= n_reg + 1'b1;
            if (dx_reg == x1)
            begin
                dx_reg   <= x0;
                dy_reg   <= dy_reg + 1'b1;
                base_reg <= base_reg + ROW_STEP;
            end
            else
            begin
                dx_reg <= dx_reg + 1'b1;
            end
        end
        p_idx_reg  <= n_reg;
        p_last_reg <= (dx_reg == x1) && (dy_reg == y1);

        if (emit)
        begin
            out_value_reg <= emit_value;
            out_idx_reg   <= emit_idx;
            out_last_reg  <= emit_last;
            out_err_reg   <= emit_err;
            out_event_reg <= det_event;
            out_below_reg <= below_upd;
        end
    end

    assign result_strobe   = out_strobe_reg;
    assign result_value    = out_value_reg;
    assign element_index   = out_idx_reg;
    assign last_result     = out_last_reg;
    assign below_threshold = out_below_reg;
    assign threshold_event = out_event_reg;
    assign result_status   = out_err_reg;

endmodule

`default_nettype wire

@@ rtl/core/tzr_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tzr_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        frame_last,
    input wire logic        result_strobe,
    input wire logic [15:0] result_value,
    input wire logic [5:0]  element_index,
    input wire logic        last_result,
    input wire logic        threshold_event,
    input wire logic        result_status
);

    a_empty_item: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && result_status |-> last_result && (result_value == 16'd0)
            && (element_index == 6'd0) && !threshold_event)
        else $error("no-valid item malformed");

    a_list_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && !last_result |=> result_strobe
            && (element_index == $past(element_index) + 6'd1))
        else $error("area list item missing or out of order");

    a_list_no_event: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && !last_result |-> !threshold_event && !result_status)
        else $error("event or error flag on a list item");

    a_frame_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && frame_last |=> busy)
        else $error("frame end did not raise busy");

endmodule

bind tof_zone_reduce_threshold_unit tzr_checker u_tzr_checker (.*);

`default_nettype wire
